/* rtl/core/i2cm_pkg.sv */
// Package for the I2C master transfer engine: payload structs, command kind
// codes, config register indices and reset value constants. No dependencies.
package i2cm_pkg;

    typedef struct packed {
        logic [1:0]  kind;
        logic        scl_in;
        logic        sda_in;
        logic [7:0]  address_byte;
        logic [15:0] byte_count;
        logic        send_stop;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic       scl_drive_low;
        logic       sda_drive_low;
        logic       busy_res;
        logic       done_res;
        logic       success;
        logic [7:0] read_data;
        logic       read_valid;
        logic       need_data;
    } t_out_item;

    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;
    localparam logic [1:0] KIND_BEGIN  = 2'd2;
    localparam logic [1:0] KIND_SUPPLY = 2'd3;

    localparam logic [1:0] REG_PHASE_DELAY = 2'd0;
    localparam logic [1:0] REG_STRETCH_TO  = 2'd1;
    localparam logic [1:0] REG_CLEAR_PULSE = 2'd2;

    localparam logic [7:0]  RST_PHASE_DELAY = 8'd4;
    localparam logic [15:0] RST_STRETCH_TO  = 16'd1000;
    localparam logic [4:0]  RST_CLEAR_PULSE = 5'd18;

endpackage

/* rtl/core/i2c_master_transfer_engine.sv */
// I2C master transfer engine: top level holding the tick-driven sequencer.
// Depends on i2cm_pkg for payload types and constants.
//
// Usage: every input transaction is one time tick carrying sampled SCL and
// SDA levels, optionally with a command (bus clear, begin transfer, or supply
// of the next write byte). Each accepted transaction produces exactly one
// result transaction with the SCL/SDA pull-down controls and status flags.
// Configuration registers (phase delay, stretch timeout, bus clear pulse
// limit) are written over the cfg channel, index 0..2. The user must write
// them only while idle; the block itself does not enforce it.
// The sequencer state and the result register are updated at the edge that
// accepts the item, and the result appears on the output the cycle after.
// Throughput is one item per cycle unless the receiver stalls: the sequencer
// step is a short piece of combinational logic between the state registers
// and the result register. When the receiver stalls, the result register
// holds and the input side stalls only if the result register is still full
// and cannot drain; the stall path is a single register stage.
// After reset the engine is idle, both lines are released, and the
// configuration registers hold their documented reset values.
module i2c_master_transfer_engine
    import i2cm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_BC_CHECK, PH_BC_HIGH, PH_BC_SAMPLE, PH_WAIT, PH_ST_REL,
        PH_ST_LOW, PH_ST_SCL, PH_WB_BEGIN, PH_WB_BIT, PH_WB_BIT_DONE,
        PH_WB_ACKW, PH_WB_ACK, PH_WAIT_DATA, PH_RB_BEGIN, PH_RB_BIT,
        PH_RB_SAMPLE, PH_RB_ACK, PH_RB_ACKW, PH_RB_END, PH_SP_BEGIN,
        PH_SP_REL, PH_SP_END, PH_FINISH
    } t_phase;

    logic [7:0]  r_cfg_delay;
    logic [15:0] r_cfg_to;
    logic [4:0]  r_cfg_pulses;

    t_phase      r_phase, n_phase, r_resume, n_resume;
    logic [3:0]  r_bit, n_bit;
    logic [7:0]  r_shift, n_shift;
    logic [15:0] r_left, n_left;
    logic [7:0]  r_dly, n_dly;
    logic [15:0] r_str, n_str;
    logic        r_ok, n_ok, r_rmode, n_rmode, r_stopw, n_stopw;
    logic [4:0]  r_pulse, n_pulse;
    logic        r_wbr, n_wbr;
    logic [7:0]  r_wbh, n_wbh;
    logic        r_scl, n_scl, r_sda, n_sda, r_to, n_to, r_isaddr, n_isaddr;
    logic        done, succ, rv;
    logic [7:0]  rd;
    logic        accept;
    logic        r_ovalid;
    t_out_item   r_out;
    logic [7:0]  hold_val;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_ovalid && i_stall;
    assign accept      = i_valid && !o_stall;
    assign o_valid     = r_ovalid;
    assign o_data      = r_out;
    assign hold_val    = (r_cfg_delay == 8'd0) ? 8'd1 : r_cfg_delay;

    always_comb begin
        logic        adv;
        logic [7:0]  dtmp;
        t_phase      nxt;
        n_phase = r_phase; n_resume = r_resume; n_bit = r_bit; n_shift = r_shift;
        n_left = r_left; n_dly = r_dly; n_str = r_str; n_ok = r_ok;
        n_rmode = r_rmode; n_stopw = r_stopw; n_pulse = r_pulse; n_wbr = r_wbr;
        n_wbh = r_wbh; n_scl = r_scl; n_sda = r_sda; n_to = r_to;
        n_isaddr = r_isaddr;
        done = 1'b0; succ = 1'b0; rv = 1'b0; rd = 8'd0;
        adv = 1'b1; dtmp = 8'd0; nxt = PH_IDLE;

        if (i_data.kind == KIND_SUPPLY) begin
            n_wbh = i_data.data_byte;
            n_wbr = 1'b1;
        end

        if (r_phase == PH_IDLE && i_data.kind == KIND_CLEAR) begin
            n_ok = 1'b1; n_pulse = 5'd0; n_scl = 1'b0; n_sda = 1'b0;
            n_dly = hold_val; n_phase = PH_BC_CHECK;
        end else if (r_phase == PH_IDLE && i_data.kind == KIND_BEGIN) begin
            n_ok = 1'b1; n_rmode = i_data.address_byte[0];
            n_stopw = i_data.send_stop; n_left = i_data.byte_count;
            n_shift = i_data.address_byte; n_isaddr = 1'b1; n_wbr = 1'b0;
            n_to = 1'b0; n_sda = 1'b0;
            n_dly = hold_val; n_phase = PH_ST_REL;
        end else begin
            if (r_dly != 8'd0) begin
                dtmp  = r_dly - 8'd1;
                n_dly = dtmp;
                if (dtmp != 8'd0) adv = 1'b0;
            end
            if (adv) begin
                unique case (r_phase)
                    PH_IDLE: ;
                    PH_BC_CHECK: begin
                        if (i_data.sda_in && i_data.scl_in) begin
                            done = 1'b1; succ = 1'b1; n_phase = PH_IDLE;
                        end else if (i_data.scl_in && r_cfg_pulses != 5'd0) begin
                            n_scl = 1'b1; n_dly = hold_val; n_phase = PH_BC_HIGH;
                        end else begin
                            done = 1'b1; n_phase = PH_IDLE;
                        end
                    end
                    PH_BC_HIGH: begin
                        n_scl = 1'b0; n_dly = hold_val; n_phase = PH_BC_SAMPLE;
                    end
                    PH_BC_SAMPLE: begin
                        n_pulse = r_pulse + 5'd1;
                        if (i_data.sda_in) begin
                            done = 1'b1; succ = 1'b1; n_phase = PH_IDLE;
                        end else if (n_pulse >= r_cfg_pulses) begin
                            done = 1'b1; n_phase = PH_IDLE;
                        end else begin
                            n_scl = 1'b1; n_dly = hold_val; n_phase = PH_BC_HIGH;
                        end
                    end
                    PH_WAIT: begin
                        if (i_data.scl_in) begin
                            n_to = 1'b0; n_dly = hold_val; n_phase = r_resume;
                        end else if (r_str >= r_cfg_to) begin
                            n_to = 1'b1; n_phase = r_resume;
                        end else begin
                            n_str = r_str + 16'd1;
                        end
                    end
                    PH_ST_REL: begin
                        n_scl = 1'b0; n_str = 16'd0; n_resume = PH_ST_LOW;
                        n_phase = PH_WAIT;
                    end
                    PH_ST_LOW: begin
                        if (r_to) begin
                            n_ok = 1'b0; n_phase = PH_WB_BEGIN;
                        end else begin
                            n_sda = 1'b1; n_dly = hold_val; n_phase = PH_ST_SCL;
                        end
                    end
                    PH_ST_SCL: begin
                        n_scl = 1'b1; n_dly = hold_val; n_phase = PH_WB_BEGIN;
                    end
                    PH_WB_BEGIN: begin
                        n_scl = 1'b1; n_bit = 4'd0; n_dly = hold_val;
                        n_phase = PH_WB_BIT;
                    end
                    PH_WB_BIT: begin
                        n_sda = !r_shift[7];
                        n_scl = 1'b0; n_str = 16'd0; n_resume = PH_WB_BIT_DONE;
                        n_phase = PH_WAIT;
                    end
                    PH_WB_BIT_DONE: begin
                        if (r_to) begin
                            n_phase = PH_WB_ACKW;
                        end else begin
                            n_scl = 1'b1; n_shift = {r_shift[6:0], 1'b0};
                            n_bit = r_bit + 4'd1; n_dly = hold_val;
                            n_phase = (n_bit >= 4'd8) ? PH_WB_ACKW : PH_WB_BIT;
                        end
                    end
                    PH_WB_ACKW: begin
                        n_sda = 1'b0; n_scl = 1'b0; n_str = 16'd0;
                        n_resume = PH_WB_ACK; n_phase = PH_WAIT;
                    end
                    PH_WB_ACK: begin
                        if (r_to || i_data.sda_in) n_ok = 1'b0;
                        n_scl = 1'b1;
                        if (r_isaddr) begin
                            if (r_left == 16'd0) begin
                                n_ok = 1'b0; nxt = PH_FINISH;
                            end else if (!n_ok) begin
                                nxt = PH_SP_BEGIN;
                            end else begin
                                nxt = r_rmode ? PH_RB_BEGIN : PH_WAIT_DATA;
                            end
                        end else if (n_ok && r_left != 16'd0) begin
                            nxt = PH_WAIT_DATA;
                        end else begin
                            nxt = (r_stopw || !n_ok) ? PH_SP_BEGIN : PH_FINISH;
                        end
                        n_dly = hold_val; n_phase = nxt;
                    end
                    PH_WAIT_DATA: begin
                        // A byte supplied on this very tick is taken at once.
                        if (n_wbr) begin
                            n_shift = n_wbh; n_wbr = 1'b0;
                            n_isaddr = 1'b0;
                            if (r_left != 16'd0) n_left = r_left - 16'd1;
                            n_phase = PH_WB_BEGIN;
                        end
                    end
                    PH_RB_BEGIN: begin
                        n_sda = 1'b0; n_shift = 8'd0; n_bit = 4'd0;
                        if (r_left != 16'd0) n_left = r_left - 16'd1;
                        n_phase = PH_RB_BIT;
                    end
                    PH_RB_BIT: begin
                        n_scl = 1'b0; n_str = 16'd0; n_resume = PH_RB_SAMPLE;
                        n_phase = PH_WAIT;
                    end
                    PH_RB_SAMPLE: begin
                        if (r_to) begin
                            n_phase = PH_RB_ACK;
                        end else begin
                            if (i_data.sda_in) n_shift = r_shift | (8'h80 >> r_bit[2:0]);
                            n_scl = 1'b1; n_bit = r_bit + 4'd1; n_dly = hold_val;
                            n_phase = (n_bit >= 4'd8) ? PH_RB_ACK : PH_RB_BIT;
                        end
                    end
                    PH_RB_ACK: begin
                        rv = 1'b1; rd = r_shift;
                        n_sda = (r_left != 16'd0);
                        n_dly = hold_val; n_phase = PH_RB_ACKW;
                    end
                    PH_RB_ACKW: begin
                        n_scl = 1'b0; n_str = 16'd0; n_resume = PH_RB_END;
                        n_phase = PH_WAIT;
                    end
                    PH_RB_END: begin
                        if (r_to) n_ok = 1'b0;
                        n_scl = 1'b1; n_dly = hold_val;
                        if (n_ok && r_left != 16'd0) n_phase = PH_RB_BEGIN;
                        else n_phase = (r_stopw || !n_ok) ? PH_SP_BEGIN : PH_FINISH;
                    end
                    PH_SP_BEGIN: begin
                        n_sda = 1'b1; n_dly = hold_val; n_phase = PH_SP_REL;
                    end
                    PH_SP_REL: begin
                        n_scl = 1'b0; n_str = 16'd0; n_resume = PH_SP_END;
                        n_phase = PH_WAIT;
                    end
                    PH_SP_END: begin
                        if (r_to) begin
                            n_ok = 1'b0; n_phase = PH_FINISH;
                        end else begin
                            n_sda = 1'b0; n_dly = hold_val; n_phase = PH_FINISH;
                        end
                    end
                    PH_FINISH: begin
                        done = 1'b1; succ = r_ok; n_phase = PH_IDLE;
                    end
                    default: begin
                        n_phase = PH_IDLE; n_dly = 8'd0;
                    end
                endcase
            end
        end
    end

    // Payload registers; write_byte_hold is only read once written.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_wbh  <= n_wbh;
            r_shift <= n_shift;
            r_out.scl_drive_low <= n_scl;
            r_out.sda_drive_low <= n_sda;
            r_out.busy_res      <= (n_phase != PH_IDLE);
            r_out.done_res      <= done;
            r_out.success       <= succ;
            r_out.read_data     <= rd;
            r_out.read_valid    <= rv;
            r_out.need_data     <= (n_phase == PH_WAIT_DATA) && (n_dly == 8'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_delay  <= RST_PHASE_DELAY;
            r_cfg_to     <= RST_STRETCH_TO;
            r_cfg_pulses <= RST_CLEAR_PULSE;
            r_phase <= PH_IDLE; r_resume <= PH_IDLE; r_bit <= 4'd0;
            r_left <= 16'd0; r_dly <= 8'd0; r_str <= 16'd0; r_ok <= 1'b1;
            r_rmode <= 1'b0; r_stopw <= 1'b0; r_pulse <= 5'd0; r_wbr <= 1'b0;
            r_scl <= 1'b0; r_sda <= 1'b0; r_to <= 1'b0; r_isaddr <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_PHASE_DELAY: r_cfg_delay  <= i_cfg_data[7:0];
                    REG_STRETCH_TO:  r_cfg_to     <= i_cfg_data;
                    REG_CLEAR_PULSE: r_cfg_pulses <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_phase <= n_phase; r_resume <= n_resume; r_bit <= n_bit;
                r_left <= n_left; r_dly <= n_dly; r_str <= n_str; r_ok <= n_ok;
                r_rmode <= n_rmode; r_stopw <= n_stopw; r_pulse <= n_pulse;
                r_wbr <= n_wbr; r_scl <= n_scl; r_sda <= n_sda; r_to <= n_to;
                r_isaddr <= n_isaddr;
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

endmodule

/* rtl/core/i2cm_checker.sv */
// Port-level checker for the I2C master transfer engine, with its bind.
// Depends on i2cm_pkg for the payload types.
module i2cm_checker
    import i2cm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_stall,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_data
);

    // A finished command always leaves the engine idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.done_res |-> !o_data.busy_res)
        else $error("done reported while still busy");

    // Success is only reported together with done.
    a_succ_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.success |-> o_data.done_res)
        else $error("success without done");

    // Read data is zero unless a read byte completed.
    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.read_valid |-> o_data.read_data == 8'd0)
        else $error("read data without read valid");

    // A stalled result stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    // The input is only held off while a result waits on a stalled receiver.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a waiting result");

endmodule

bind i2c_master_transfer_engine i2cm_checker u_i2cm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
